FILE: rtl/assert_macros.svh
// Assertion macros for the RTL, used by mccd_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/mccd_pkg.sv
// Shared constants and types for the minimum coin change block.
package mccd_pkg;

	localparam int MAX_AMOUNT = 1023;
	localparam int MAX_COINS  = 7;

	localparam int AMT_W   = 10;
	localparam int COIN_W  = 10;
	localparam int COUNT_W = 10;
	localparam int NUM_W   = 3;
	localparam int ENTRY_W = COUNT_W + 1;
	localparam int VALID_POS = COUNT_W;

	localparam int TBL_DEPTH = MAX_AMOUNT + 1;
	localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

	localparam int NUM_COIN_REGS = 7;
	localparam int COIN_IDX_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
	localparam int COIN_CNT_W = COIN_IDX_W + 1;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int PADDR_W   = REG_IDX_W + 2;
	localparam int PDATA_W   = 32;

	localparam logic [REG_IDX_W-1:0] REG_NUM_COINS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COIN_A    = 3'd1;

	typedef struct packed {
		logic [NUM_W-1:0]                       used;
		logic [NUM_COIN_REGS-1:0][COIN_W-1:0]   coins;
	} cfg_t;

	typedef struct packed {
		logic                 we;
		logic [TBL_AW-1:0]    waddr;
		logic [ENTRY_W-1:0]   wdata;
		logic [TBL_AW-1:0]    raddr;
	} tbl_req_t;

endpackage

FILE: rtl/mccd_regs.sv
// APB configuration registers: coin count and seven denominations.
module mccd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mccd_pkg::PADDR_W-1:0]  paddr,
	input  logic [mccd_pkg::PDATA_W-1:0]  pwdata,
	output logic [mccd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output mccd_pkg::cfg_t                cfg
);

	logic [mccd_pkg::NUM_W-1:0]                                 num_q;
	logic [mccd_pkg::NUM_COIN_REGS-1:0][mccd_pkg::COIN_W-1:0]   coin_q;
	logic [mccd_pkg::REG_IDX_W-1:0]                             reg_idx;
	logic [mccd_pkg::REG_IDX_W-1:0]                             coin_sel;
	logic                                                       wr_en;

	assign reg_idx  = paddr[mccd_pkg::PADDR_W-1:2];
	assign coin_sel = reg_idx - mccd_pkg::REG_COIN_A;
	assign wr_en    = psel && penable && pwrite;
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q     <= '0;
			coin_q    <= '0;
			coin_q[0] <= mccd_pkg::COIN_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				mccd_pkg::REG_NUM_COINS: begin
					num_q <= pwdata[mccd_pkg::NUM_W-1:0];
				end
				default: begin
					coin_q[coin_sel] <= pwdata[mccd_pkg::COIN_W-1:0];
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mccd_pkg::REG_NUM_COINS: begin
				prdata = mccd_pkg::PDATA_W'(num_q);
			end
			default: begin
				prdata = mccd_pkg::PDATA_W'(coin_q[coin_sel]);
			end
		endcase
	end

	// Counts above the build-time coin limit are clamped here once.
	always_comb begin
		cfg.coins = coin_q;
		if (int'(num_q) > mccd_pkg::MAX_COINS) begin
			cfg.used = mccd_pkg::NUM_W'(mccd_pkg::MAX_COINS);
		end else begin
			cfg.used = num_q;
		end
	end

endmodule

FILE: rtl/mccd_table.sv
// Table of best coin counts: one write port, one registered read port.
module mccd_table (
	input  logic                           clk,
	input  mccd_pkg::tbl_req_t             req,
	output logic [mccd_pkg::ENTRY_W-1:0]   rdata
);

	logic [mccd_pkg::ENTRY_W-1:0] mem_q [mccd_pkg::TBL_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[req.raddr];
	end

endmodule

FILE: rtl/mccd_core.sv
// Sequencer and shared compare unit that rebuild the table for one query.
`include "assert_macros.svh"

module mccd_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mccd_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mccd_pkg::AMT_W-1:0]     target_amount,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mccd_pkg::COUNT_W-1:0]   min_count,
	output logic                           reachable,
	output mccd_pkg::tbl_req_t             tbl_req,
	input  logic [mccd_pkg::ENTRY_W-1:0]   tbl_rdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_LAST = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                         state_q;
	logic [mccd_pkg::AMT_W-1:0]         tgt_q;
	logic [mccd_pkg::AMT_W-1:0]         idx_q;
	logic [mccd_pkg::COIN_IDX_W-1:0]    j_q;
	logic                               pend_s1;
	logic                               found_q;
	logic [mccd_pkg::COUNT_W-1:0]       best_q;
	logic [mccd_pkg::COUNT_W-1:0]       res_count_q;
	logic                               res_reach_q;
	logic                               out_valid_q;
	logic [mccd_pkg::COUNT_W-1:0]       min_count_q;
	logic                               reachable_q;

	logic [mccd_pkg::COIN_W-1:0]        coin;
	logic                               coin_active;
	logic                               issue_ok;
	logic                               last_coin;
	logic [mccd_pkg::AMT_W-1:0]         back_idx;
	logic [mccd_pkg::COUNT_W-1:0]       rd_cnt;
	logic                               rd_ok;
	logic [mccd_pkg::COUNT_W-1:0]       cand;
	logic                               take;
	logic                               m_found;
	logic [mccd_pkg::COUNT_W-1:0]       m_best;
	logic                               load_out;

	// Address side of the shared unit: one coin per cycle while scanning.
	assign coin        = cfg.coins[j_q];
	assign coin_active = mccd_pkg::COIN_CNT_W'(j_q) < mccd_pkg::COIN_CNT_W'(cfg.used);
	assign issue_ok    = (state_q == ST_SCAN) && coin_active && (coin != '0)
	                     && (mccd_pkg::AMT_W'(coin) <= idx_q);
	assign back_idx    = idx_q - mccd_pkg::AMT_W'(coin);
	assign last_coin   = (mccd_pkg::COIN_CNT_W'(j_q) + mccd_pkg::COIN_CNT_W'(1)
	                      >= mccd_pkg::COIN_CNT_W'(cfg.used))
	                     || (j_q == mccd_pkg::COIN_IDX_W'(mccd_pkg::MAX_COINS - 1));

	// Compare side: folds the entry read in the previous cycle into the running best.
	assign rd_cnt  = tbl_rdata[mccd_pkg::COUNT_W-1:0];
	assign rd_ok   = pend_s1 && tbl_rdata[mccd_pkg::VALID_POS];
	assign cand    = (&rd_cnt) ? rd_cnt : rd_cnt + mccd_pkg::COUNT_W'(1);
	assign take    = rd_ok && (!found_q || (cand < best_q));
	assign m_found = found_q || rd_ok;
	assign m_best  = take ? cand : best_q;

	always_comb begin
		tbl_req.raddr = mccd_pkg::TBL_AW'(back_idx);
		tbl_req.we    = 1'b0;
		tbl_req.waddr = '0;
		tbl_req.wdata = '0;
		case (state_q)
			ST_INIT: begin
				tbl_req.we    = 1'b1;
				tbl_req.wdata = mccd_pkg::ENTRY_W'(1) << mccd_pkg::VALID_POS;
			end
			ST_LAST: begin
				tbl_req.we    = 1'b1;
				tbl_req.waddr = mccd_pkg::TBL_AW'(idx_q);
				tbl_req.wdata = m_found ? {1'b1, m_best} : '0;
			end
			default: begin
				tbl_req.we = 1'b0;
			end
		endcase
	end

	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign min_count = min_count_q;
	assign reachable = reachable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= issue_ok;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (int'(target_amount) > mccd_pkg::MAX_AMOUNT) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					found_q <= 1'b0;
					if (tgt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					found_q <= m_found;
					if (last_coin) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					found_q <= 1'b0;
					if (idx_q == tgt_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			min_count_q <= res_count_q;
			reachable_q <= res_reach_q;
		end
		case (state_q)
			ST_IDLE: begin
				tgt_q       <= target_amount;
				res_count_q <= '0;
				res_reach_q <= 1'b0;
			end
			ST_INIT: begin
				idx_q       <= mccd_pkg::AMT_W'(1);
				j_q         <= '0;
				res_count_q <= '0;
				res_reach_q <= 1'b1;
			end
			ST_SCAN: begin
				best_q <= m_best;
				j_q    <= j_q + mccd_pkg::COIN_IDX_W'(1);
			end
			ST_LAST: begin
				idx_q       <= idx_q + mccd_pkg::AMT_W'(1);
				j_q         <= '0;
				res_count_q <= m_found ? m_best : '0;
				res_reach_q <= m_found;
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

	`ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == ST_INIT || state_q == ST_DONE)
	`ASSERT_IMPLIES(a_scan_in_range, clk, arst_n, state_q == ST_SCAN, idx_q <= tgt_q && idx_q != '0)
	`ASSERT_IMPLIES(a_read_in_loop, clk, arst_n, pend_s1, state_q == ST_SCAN || state_q == ST_LAST)
	`ASSERT_NEXT(a_unreach_zero, clk, arst_n, load_out, out_valid_q && (reachable_q || min_count_q == '0))

endmodule

FILE: rtl/min_coin_change_dp.sv
// Top level of the minimum coin change block.
// Each query amount is answered with the fewest coins drawn, with repetition, from the
// first num_coins denominations; reachable is low and min_count zero when no combination
// fits. The best-count table is rebuilt from zero for every query by one shared subtract
// and compare unit: each entry up to the amount takes one scan step per coin (at least
// one) and then one table write. The block takes a new query only when the previous one
// is finished, though a finished result may still wait in the output register. The table
// needs no clearing after reset. Configuration must be written over APB only while the
// block is idle; the block itself does not enforce this.
module min_coin_change_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mccd_pkg::PADDR_W-1:0]    paddr,
	input  logic [mccd_pkg::PDATA_W-1:0]    pwdata,
	output logic [mccd_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mccd_pkg::AMT_W-1:0]      target_amount,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mccd_pkg::COUNT_W-1:0]    min_count,
	output logic                            reachable
);

	mccd_pkg::cfg_t                 cfg;
	mccd_pkg::tbl_req_t             tbl_req;
	logic [mccd_pkg::ENTRY_W-1:0]   tbl_rdata;

	mccd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mccd_table u_table (
		.clk   (clk),
		.req   (tbl_req),
		.rdata (tbl_rdata)
	);

	mccd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.target_amount (target_amount),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.min_count     (min_count),
		.reachable     (reachable),
		.tbl_req       (tbl_req),
		.tbl_rdata     (tbl_rdata)
	);

endmodule

FILE: tb/tb_min_coin_change_dp.sv
// Self-checking testbench for the minimum coin change block: directed probes, then random queries.
`timescale 1ns / 100ps

module tb_min_coin_change_dp;

	typedef struct {
		logic [mccd_pkg::AMT_W-1:0]   amt;
		logic [mccd_pkg::COUNT_W-1:0] cnt;
		logic                         reach;
	} change_t;

	typedef struct {
		int                           setting;
		logic [mccd_pkg::AMT_W-1:0]   amt;
		bit                           typed;
		logic [mccd_pkg::COUNT_W-1:0] cnt;
		logic                         reach;
	} probe_t;

	localparam int N_PROBES   = 16;
	localparam int N_SETTINGS = 4;
	localparam int N_PHASES   = 5;
	localparam int PHASE_LEN  = 20;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [mccd_pkg::PADDR_W-1:0]   paddr = '0;
	logic [mccd_pkg::PDATA_W-1:0]   pwdata = '0;
	logic [mccd_pkg::PDATA_W-1:0]   prdata;
	logic                           pready;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [mccd_pkg::AMT_W-1:0]     target_amount = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [mccd_pkg::COUNT_W-1:0]   min_count;
	logic                           reachable;

	// Shadow of the configuration registers, starting from their reset values.
	logic [mccd_pkg::NUM_W-1:0]  cfg_num = '0;
	logic [mccd_pkg::COIN_W-1:0] cfg_coin [mccd_pkg::NUM_COIN_REGS] =
		'{10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0};

	change_t pending_change [$];
	int      mismatches = 0;
	bit      quiet = 1'b1;

	// Denomination settings for the directed probes; setting 0 is the state after reset.
	logic [mccd_pkg::NUM_W-1:0]  set_num [N_SETTINGS] = '{3'd0, 3'd3, 3'd7, 3'd1};
	logic [mccd_pkg::COIN_W-1:0] set_coins [N_SETTINGS][mccd_pkg::NUM_COIN_REGS] = '{
		'{10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
		'{10'd1, 10'd5, 10'd10, 10'd2, 10'd3, 10'd4, 10'd6},
		'{10'd0, 10'd1023, 10'd7, 10'd0, 10'd3, 10'd1023, 10'd12},
		'{10'd1023, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1}
	};

	probe_t probes [N_PROBES] = '{
		'{0, 10'd0,    1'b1, 10'd0, 1'b1},
		'{0, 10'd5,    1'b1, 10'd0, 1'b0},
		'{0, 10'd1023, 1'b1, 10'd0, 1'b0},
		'{1, 10'd0,    1'b1, 10'd0, 1'b1},
		'{1, 10'd1,    1'b1, 10'd1, 1'b1},
		'{1, 10'd7,    1'b0, 10'd0, 1'b0},
		'{1, 10'd1023, 1'b0, 10'd0, 1'b0},
		'{1, 10'd999,  1'b0, 10'd0, 1'b0},
		'{2, 10'd1023, 1'b1, 10'd1, 1'b1},
		'{2, 10'd1,    1'b1, 10'd0, 1'b0},
		'{2, 10'd2,    1'b1, 10'd0, 1'b0},
		'{2, 10'd10,   1'b0, 10'd0, 1'b0},
		'{2, 10'd1022, 1'b0, 10'd0, 1'b0},
		'{3, 10'd1023, 1'b1, 10'd1, 1'b1},
		'{3, 10'd512,  1'b1, 10'd0, 1'b0},
		'{3, 10'd1,    1'b1, 10'd0, 1'b0}
	};

	min_coin_change_dp i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.target_amount (target_amount),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.min_count     (min_count),
		.reachable     (reachable)
	);

	always #10 clk = ~clk;

	initial begin
		#(100_000_000);
		$display("min_coin_change_dp regression: fail");
		$finish;
	end

	// Fewest coins for an amount under the current shadow configuration.
	function automatic change_t predict_change(input logic [mccd_pkg::AMT_W-1:0] amt);
		logic [mccd_pkg::ENTRY_W-1:0] best_at [mccd_pkg::TBL_DEPTH];
		logic [mccd_pkg::ENTRY_W-1:0] prev;
		logic [mccd_pkg::COIN_W-1:0]  coin;
		logic [mccd_pkg::COUNT_W-1:0] best;
		logic [mccd_pkg::COUNT_W-1:0] cand;
		logic                         found;
		change_t                      res;
		int                           i;
		int                           j;
		best_at[0] = {1'b1, {mccd_pkg::COUNT_W{1'b0}}};
		for (i = 1; i <= int'(amt); i++) begin
			found = 1'b0;
			best = '0;
			for (j = 0; j < int'(cfg_num); j++) begin
				coin = cfg_coin[j];
				if (coin != 0 && int'(coin) <= i) begin
					prev = best_at[i - int'(coin)];
					if (prev[mccd_pkg::VALID_POS]) begin
						cand = (&prev[mccd_pkg::COUNT_W-1:0])
							? prev[mccd_pkg::COUNT_W-1:0]
							: prev[mccd_pkg::COUNT_W-1:0] + 1'b1;
						if (!found || cand < best) begin
							best = cand;
							found = 1'b1;
						end
					end
				end
			end
			best_at[i] = found ? {1'b1, best} : '0;
		end
		res.amt = amt;
		res.reach = best_at[amt][mccd_pkg::VALID_POS];
		res.cnt = res.reach ? best_at[amt][mccd_pkg::COUNT_W-1:0] : '0;
		return res;
	endfunction

	// Leaves psel high so that back-to-back writes need no second assignment in one step.
	task automatic apb_write(input logic [mccd_pkg::REG_IDX_W-1:0] idx,
			input logic [mccd_pkg::PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == mccd_pkg::REG_NUM_COINS)
			cfg_num = data[mccd_pkg::NUM_W-1:0];
		else
			cfg_coin[idx - mccd_pkg::REG_COIN_A] = data[mccd_pkg::COIN_W-1:0];
	endtask

	// Upper data bits are filled with noise; the registers keep only their own width.
	task automatic program_coins(input logic [mccd_pkg::NUM_W-1:0] num,
			input logic [mccd_pkg::COIN_W-1:0] cset [mccd_pkg::NUM_COIN_REGS]);
		int j;
		for (j = 0; j < mccd_pkg::NUM_COIN_REGS; j++)
			apb_write(mccd_pkg::REG_COIN_A + mccd_pkg::REG_IDX_W'(j),
				{$urandom} & ~32'h3ff | 32'(cset[j]));
		apb_write(mccd_pkg::REG_NUM_COINS, {$urandom} & ~32'h7 | 32'(num));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_amount(input logic [mccd_pkg::AMT_W-1:0] amt, input bit typed,
			input logic [mccd_pkg::COUNT_W-1:0] cnt, input logic reach);
		int unsigned gap;
		change_t     want;
		gap = quiet ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		target_amount <= amt;
		do @(posedge clk); while (!in_ready);
		if (typed) begin
			want.amt = amt;
			want.cnt = cnt;
			want.reach = reach;
		end else begin
			want = predict_change(amt);
		end
		pending_change.push_back(want);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_change.size() != 0) @(posedge clk);
	endtask

	// Result side: one stall draw per transfer, then compare with the oldest expectation.
	initial begin
		int unsigned gap;
		change_t     want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_change.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result transfer, count %0d reachable %0b",
						$realtime, min_count, reachable);
			end else begin
				want = pending_change.pop_front();
				if (min_count !== want.cnt || reachable !== want.reach) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: amount %0d: expected count %0d reachable %0b, got %0d %0b",
							$realtime, want.amt, want.cnt, want.reach, min_count, reachable);
				end
			end
		end
	end

	initial begin
		logic [mccd_pkg::COIN_W-1:0] cset [mccd_pkg::NUM_COIN_REGS];
		logic [mccd_pkg::NUM_W-1:0]  num;
		logic [mccd_pkg::AMT_W-1:0]  amt;
		int                          cur;
		int                          k;
		int                          j;
		int                          p;
		int                          roll;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur = 0;
		for (k = 0; k < N_PROBES; k++) begin
			if (probes[k].setting != cur) begin
				drain();
				cur = probes[k].setting;
				for (j = 0; j < mccd_pkg::NUM_COIN_REGS; j++)
					cset[j] = set_coins[cur][j];
				program_coins(set_num[cur], cset);
			end
			send_amount(probes[k].amt, probes[k].typed, probes[k].cnt, probes[k].reach);
		end

		// Mostly small amounts keep the run short; a few go right up to the top of the range.
		for (p = 0; p < N_PHASES; p++) begin
			drain();
			for (j = 0; j < mccd_pkg::NUM_COIN_REGS; j++) begin
				roll = $urandom_range(0, 9);
				if (roll == 0)
					cset[j] = '0;
				else if (roll == 1)
					cset[j] = mccd_pkg::COIN_W'($urandom_range(0, 1023));
				else
					cset[j] = mccd_pkg::COIN_W'($urandom_range(1, 40));
			end
			num = (p == 0) ? 3'd7 : mccd_pkg::NUM_W'($urandom_range(0, 7));
			program_coins(num, cset);
			quiet = ($urandom_range(0, 3) == 0);
			for (k = 0; k < PHASE_LEN; k++) begin
				if ($urandom_range(0, 15) == 0)
					amt = mccd_pkg::AMT_W'($urandom_range(0, 1023));
				else
					amt = mccd_pkg::AMT_W'($urandom_range(0, 150));
				send_amount(amt, 1'b0, '0, 1'b0);
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("min_coin_change_dp regression: pass");
		else
			$display("min_coin_change_dp regression: fail");
		$finish;
	end

endmodule
